FILE: hdl/pgw_pkg.sv
// ----------------------------------------------------------------------------
// pgw_pkg
// Shared widths, codes and types for the four-level page table walker.
// ----------------------------------------------------------------------------
package pgw_pkg;

    localparam int VA_BITS     = 48;
    localparam int ENTRY_BITS  = 64;
    localparam int ADDR_BITS   = 52;
    localparam int STATUS_BITS = 3;
    localparam int PSIZE_BITS  = 2;
    localparam int IDX_BITS    = 9;

    // Result kinds
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Request ops
    localparam logic OP_TRANSLATE = 1'b0;
    localparam logic OP_RESPONSE  = 1'b1;

    // Walk levels
    localparam logic [1:0] LVL_PML4 = 2'd0;
    localparam logic [1:0] LVL_PDPT = 2'd1;
    localparam logic [1:0] LVL_PD   = 2'd2;
    localparam logic [1:0] LVL_PT   = 2'd3;

    // Completion status
    localparam logic [STATUS_BITS-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_PML4_NP   = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_READ_ERR  = 3'd5;
    localparam logic [STATUS_BITS-1:0] ST_REJECTED  = 3'd6;

    // Page sizes
    localparam logic [PSIZE_BITS-1:0] PS_4K = 2'd0;
    localparam logic [PSIZE_BITS-1:0] PS_2M = 2'd1;
    localparam logic [PSIZE_BITS-1:0] PS_1G = 2'd2;

    // Entry flag bits
    localparam int PRESENT_BIT = 0;
    localparam int LARGE_BIT   = 7;

    typedef struct packed {
        logic                   kind;
        logic [ADDR_BITS-1:0]   address;
        logic [STATUS_BITS-1:0] status;
        logic [PSIZE_BITS-1:0]  page_size;
    } result_t;

    // Pick the 9-bit table index of a virtual address for one level
    function automatic logic [IDX_BITS-1:0] level_index(
        input logic [VA_BITS-1:0] va,
        input logic [1:0]         lvl
    );
        logic [IDX_BITS-1:0] idx;
        unique case (lvl)
            LVL_PML4: idx = va[47:39];
            LVL_PDPT: idx = va[38:30];
            LVL_PD:   idx = va[29:21];
            LVL_PT:   idx = va[20:12];
            default:  idx = va[47:39];
        endcase
        return idx;
    endfunction

endpackage

FILE: hdl/pgw_if.sv
// ----------------------------------------------------------------------------
// pgw_if
// Handshake channels of the walker: request items, result items, config.
// ----------------------------------------------------------------------------
interface pgw_item_if;
    import pgw_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [VA_BITS-1:0]    virt_addr;
    logic [ENTRY_BITS-1:0] read_data;
    logic                  read_error;

    modport source (output valid, output op, output virt_addr, output read_data,
                    output read_error, input ready);
    modport sink   (input valid, input op, input virt_addr, input read_data,
                    input read_error, output ready);
endinterface

interface pgw_result_if;
    import pgw_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   kind;
    logic [ADDR_BITS-1:0]   address;
    logic [STATUS_BITS-1:0] status;
    logic [PSIZE_BITS-1:0]  page_size;

    modport source (output valid, output kind, output address, output status,
                    output page_size, input ready);
    modport sink   (input valid, input kind, input address, input status,
                    input page_size, output ready);
endinterface

interface pgw_cfg_if;
    import pgw_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ADDR_BITS-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/four_level_page_table_walker_core.sv
// ----------------------------------------------------------------------------
// four_level_page_table_walker_core
// Translates 48-bit virtual addresses by walking PML4, PDPT, PD and PT.
// ----------------------------------------------------------------------------
// Every request (a translate or a memory response) that is taken yields one
// registered result: either the next entry read or the finished translation.
// One request is taken per cycle while the skid entry is empty; the walk state
// and the result are computed in a single pass from the request and the walk
// registers. Results leave through an output register backed by one skid entry,
// so requests stall only when both are full. Write table_root only while idle.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_core #(
    parameter int PHYS_ADDR_BITS = 52
) (
    input  logic         clk,
    input  logic         rst_n,
    pgw_cfg_if.sink      cfg,
    pgw_item_if.sink     item,
    pgw_result_if.source result
);
    import pgw_pkg::*;

    localparam int FRAME_BITS = PHYS_ADDR_BITS - 12;

    // Configuration and walk state
    logic [FRAME_BITS-1:0]     root_reg;
    logic                      busy_reg,  busy_next;
    logic [1:0]                level_reg, level_next;
    logic [VA_BITS-1:0]        vaddr_reg, vaddr_next;
    logic [FRAME_BITS-1:0]     base_reg,  base_next;

    // Output register and skid entry
    logic    out_valid_reg, skid_valid_reg;
    result_t out_reg, skid_reg;
    result_t res_next;

    logic                      accept;
    logic                      take;
    logic [FRAME_BITS-1:0]     frame;
    logic [PHYS_ADDR_BITS-1:0] phys;

    assign accept = item.valid && item.ready;
    assign take   = out_valid_reg && result.ready;
    assign frame  = item.read_data[PHYS_ADDR_BITS-1:12];

    // Take config writes at any time
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg <= '0;
        end
        else if (cfg.valid)
        begin
            root_reg <= cfg.data[PHYS_ADDR_BITS-1:12];
        end
    end

    // Walk step: next state and the result of one request
    always_comb
    begin
        busy_next  = busy_reg;
        level_next = level_reg;
        vaddr_next = vaddr_reg;
        base_next  = base_reg;
        phys       = '0;
        res_next.kind      = KIND_DONE;
        res_next.status    = ST_REJECTED;
        res_next.page_size = PS_4K;

        priority if (item.op == OP_TRANSLATE)
        begin
            if (!busy_reg)
            begin
                busy_next     = 1'b1;
                level_next    = LVL_PML4;
                vaddr_next    = item.virt_addr;
                base_next     = root_reg;
                phys          = {root_reg, level_index(item.virt_addr, LVL_PML4), 3'b000};
                res_next.kind = KIND_READ;
                res_next.status = ST_OK;
            end
        end
        else if (!busy_reg)
        begin
            // Response with no walk running: reject, keep state
        end
        else if (item.read_error)
        begin
            busy_next       = 1'b0;
            res_next.status = ST_READ_ERR;
        end
        else if (!item.read_data[PRESENT_BIT])
        begin
            busy_next       = 1'b0;
            res_next.status = ST_PML4_NP + {1'b0, level_reg};
        end
        else if (level_reg == LVL_PDPT && item.read_data[LARGE_BIT])
        begin
            busy_next          = 1'b0;
            phys               = {item.read_data[PHYS_ADDR_BITS-1:30], vaddr_reg[29:0]};
            res_next.status    = ST_OK;
            res_next.page_size = PS_1G;
        end
        else if (level_reg == LVL_PD && item.read_data[LARGE_BIT])
        begin
            busy_next          = 1'b0;
            phys               = {item.read_data[PHYS_ADDR_BITS-1:21], vaddr_reg[20:0]};
            res_next.status    = ST_OK;
            res_next.page_size = PS_2M;
        end
        else if (level_reg == LVL_PT)
        begin
            busy_next       = 1'b0;
            phys            = {frame, vaddr_reg[11:0]};
            res_next.status = ST_OK;
        end
        else
        begin
            // Descend one level and read its entry
            base_next       = frame;
            level_next      = level_reg + 2'd1;
            phys            = {frame, level_index(vaddr_reg, level_reg + 2'd1), 3'b000};
            res_next.kind   = KIND_READ;
            res_next.status = ST_OK;
        end

        res_next.address = ADDR_BITS'(phys);
    end

    // Advance walk state on each taken request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            level_reg <= LVL_PML4;
            vaddr_reg <= '0;
            base_reg  <= '0;
        end
        else if (accept)
        begin
            busy_reg  <= busy_next;
            level_reg <= level_next;
            vaddr_reg <= vaddr_next;
            base_reg  <= base_next;
        end
    end

    // Hold requests off only when the skid entry is occupied
    assign item.ready = !skid_valid_reg;

    // Output register with one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !take)
            begin
                skid_reg <= res_next;
            end
            else
            begin
                out_reg <= res_next;
            end
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.kind      = out_reg.kind;
    assign result.address   = out_reg.address;
    assign result.status    = out_reg.status;
    assign result.page_size = out_reg.page_size;

endmodule

FILE: dv/pgw_walk_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pgw_walk_checker
// Watches the config, request and result channels of the page table walker,
// predicts each result from its own copy of the walk state, and compares.
// ----------------------------------------------------------------------------
module pgw_walk_checker (
    input  logic  clk,
    input  logic  rst_n,
    pgw_cfg_if    cfg,
    pgw_item_if   item,
    pgw_result_if result,
    output int    mismatches,
    output int    pending
);
    import pgw_pkg::*;

    // Predicted walk state
    logic [ADDR_BITS-1:0] root_reg;
    logic                 walking;
    logic [1:0]           cur_level;
    logic [VA_BITS-1:0]   held_vaddr;
    logic [ADDR_BITS-1:0] level_base;

    result_t expected_results[$];
    int      mismatch_count = 0;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("%0t: %s", $time, msg);
    endtask

    // Advance the predicted walk by one request and return the result it causes
    function automatic result_t walk_step(
        input logic                  op,
        input logic [VA_BITS-1:0]    va,
        input logic [ENTRY_BITS-1:0] entry,
        input logic                  err
    );
        result_t              r;
        logic [IDX_BITS-1:0]  idx;
        r = '0;
        r.kind   = KIND_DONE;
        r.status = ST_REJECTED;
        if (op == OP_TRANSLATE) begin
            if (!walking) begin
                walking    = 1'b1;
                cur_level  = LVL_PML4;
                held_vaddr = va;
                level_base = {root_reg[ADDR_BITS-1:12], 12'h000};
                r.kind     = KIND_READ;
                r.status   = ST_OK;
            end
        end
        else if (walking) begin
            walking = 1'b0;
            if (err)
                r.status = ST_READ_ERR;
            else if (!entry[PRESENT_BIT])
                r.status = ST_PML4_NP + {1'b0, cur_level};
            else if (cur_level == LVL_PDPT && entry[LARGE_BIT]) begin
                r.status    = ST_OK;
                r.page_size = PS_1G;
                r.address   = {entry[ADDR_BITS-1:30], held_vaddr[29:0]};
            end
            else if (cur_level == LVL_PD && entry[LARGE_BIT]) begin
                r.status    = ST_OK;
                r.page_size = PS_2M;
                r.address   = {entry[ADDR_BITS-1:21], held_vaddr[20:0]};
            end
            else if (cur_level == LVL_PT) begin
                r.status    = ST_OK;
                r.page_size = PS_4K;
                r.address   = {entry[ADDR_BITS-1:12], held_vaddr[11:0]};
            end
            else begin
                // descend one level, the walk stays open
                walking    = 1'b1;
                level_base = {entry[ADDR_BITS-1:12], 12'h000};
                cur_level  = cur_level + 2'd1;
                r.kind     = KIND_READ;
                r.status   = ST_OK;
            end
        end
        // entry read address: table base plus eight bytes per index
        if (r.kind == KIND_READ) begin
            idx       = IDX_BITS'(held_vaddr >> (39 - 9 * cur_level));
            r.address = level_base + ADDR_BITS'({idx, 3'b000});
        end
        return r;
    endfunction

    // Compare results, track config, queue predictions
    always @(posedge clk or negedge rst_n) begin
        result_t got;
        result_t want;
        if (!rst_n) begin
            root_reg   = '0;
            walking    = 1'b0;
            cur_level  = LVL_PML4;
            held_vaddr = '0;
            level_base = '0;
            expected_results.delete();
        end
        else begin
            if (result.valid && result.ready) begin
                got = {result.kind, result.address, result.status, result.page_size};
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("result 0x%0h with no request pending", got));
                else begin
                    want = expected_results.pop_front();
                    if (got.kind !== want.kind)
                        report_mismatch($sformatf("kind got %0b expected %0b",
                                                  got.kind, want.kind));
                    if (got.address !== want.address)
                        report_mismatch($sformatf("address got 0x%0h expected 0x%0h",
                                                  got.address, want.address));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status got %0d expected %0d",
                                                  got.status, want.status));
                    if (got.page_size !== want.page_size)
                        report_mismatch($sformatf("page_size got %0d expected %0d",
                                                  got.page_size, want.page_size));
                end
            end
            if (cfg.valid && cfg.ready)
                root_reg = cfg.data;
            if (item.valid && item.ready)
                expected_results.push_back(walk_step(item.op, item.virt_addr,
                                                     item.read_data, item.read_error));
        end
        pending    <= expected_results.size();
        mismatches <= mismatch_count;
    end

endmodule

FILE: dv/tb_four_level_page_table_walker_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_four_level_page_table_walker_core
// Drives translate requests and table entry responses into the walker: a
// directed set of corner walks, then random well-formed walks with injected
// rejects and failures under three idling profiles and three table roots.
// ----------------------------------------------------------------------------
module tb_four_level_page_table_walker_core;
    import pgw_pkg::*;

    localparam logic [ENTRY_BITS-1:0] ENTRY_ALL_ONES = '1;
    localparam int                    ITEMS_PER_PHASE = 660;

    logic clk;
    logic rst_n;
    int   src_idle;
    int   sink_idle;
    int   items_sent;
    int   fail_count;
    int   pending_count;

    pgw_cfg_if    cfg_ch();
    pgw_item_if   item_ch();
    pgw_result_if result_ch();

    four_level_page_table_walker_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .item   (item_ch),
        .result (result_ch)
    );

    pgw_walk_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_ch),
        .item       (item_ch),
        .result     (result_ch),
        .mismatches (fail_count),
        .pending    (pending_count)
    );

    initial clk = 1'b0;

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the result side at random
    always @(posedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= sink_idle);
    end

    // Hold off at random, then present one request until it is taken
    task automatic push_request(input logic op, input logic [VA_BITS-1:0] va,
                                input logic [ENTRY_BITS-1:0] data, input logic err);
        while ($urandom_range(99) < src_idle) begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.op         <= op;
        item_ch.virt_addr  <= va;
        item_ch.read_data  <= data;
        item_ch.read_error <= err;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_translate(input logic [VA_BITS-1:0] va);
        push_request(OP_TRANSLATE, va, {$urandom, $urandom}, 1'($urandom));
    endtask

    task automatic send_response(input logic [ENTRY_BITS-1:0] data, input logic err);
        push_request(OP_RESPONSE, VA_BITS'({$urandom, $urandom}), data, err);
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain_walker();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_table_root(input logic [ADDR_BITS-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Random walks with random entries, plus stray requests and failures
    task automatic run_random_walks(input int target);
        logic [1:0]            lvl;
        logic                  done;
        logic                  err;
        logic [ENTRY_BITS-1:0] data;
        int                    pick;
        while (items_sent < target) begin
            if ($urandom_range(99) < 5)
                send_response({$urandom, $urandom}, 1'($urandom));
            send_translate(VA_BITS'({$urandom, $urandom}));
            lvl  = LVL_PML4;
            done = 1'b0;
            while (!done) begin
                if ($urandom_range(99) < 4)
                    send_translate(VA_BITS'({$urandom, $urandom}));
                pick = $urandom_range(99);
                data = {$urandom, $urandom};
                err  = 1'b0;
                if (pick < 5) begin
                    err  = 1'b1;
                    done = 1'b1;
                end
                else if (pick < 8) begin
                    data = '0;
                    done = 1'b1;
                end
                else if (pick < 14) begin
                    data[PRESENT_BIT] = 1'b0;
                    done = 1'b1;
                end
                else begin
                    data[PRESENT_BIT] = 1'b1;
                    if (lvl == LVL_PDPT || lvl == LVL_PD) begin
                        data[LARGE_BIT] = ($urandom_range(3) == 0);
                        done = data[LARGE_BIT];
                    end
                    else if (lvl == LVL_PT)
                        done = 1'b1;
                end
                send_response(data, err);
                lvl = lvl + 2'd1;
            end
        end
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.data        <= '0;
        item_ch.valid      <= 1'b0;
        item_ch.op         <= OP_TRANSLATE;
        item_ch.virt_addr  <= '0;
        item_ch.read_data  <= '0;
        item_ch.read_error <= 1'b0;
        items_sent = 0;
        src_idle   = 7;
        sink_idle  = 49;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Highest root, low bits set: they must be ignored
        write_table_root('1);

        // Response with no walk open
        send_response(ENTRY_ALL_ONES, 1'b1);
        // Read error overrides the entry
        send_translate(48'h0);
        send_response(ENTRY_ALL_ONES, 1'b1);
        // Zero entry at PML4
        send_translate(48'hFFFF_FFFF_FFFF);
        send_response(64'h0, 1'b0);
        // Page-size bit at PML4 walks on; PDPT with present clear
        send_translate(48'h8000_4020_1008);
        send_response(ENTRY_ALL_ONES, 1'b0);
        send_response(64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
        // Full walk to a 4 KiB page, page-size bit at PT ignored
        send_translate(48'hFFFF_FFFF_FFFF);
        send_response(64'h0000_0000_0000_0001, 1'b0);
        send_response(64'h0008_0000_0000_0001, 1'b0);
        send_response(64'h7FF0_0000_0000_F001, 1'b0);
        send_response(ENTRY_ALL_ONES, 1'b0);
        // 1 GiB page at PDPT, low frame bits of the entry ignored
        send_translate(48'h5555_5555_5555);
        send_response(64'h0000_0001_2345_6003, 1'b0);
        send_response(64'hFFFF_FFFF_FFFF_FF81, 1'b0);
        // 2 MiB page at PD, with a translate rejected mid-walk
        send_translate(48'hAAAA_AAAA_AAAA);
        send_response(64'h0000_000F_FFFF_F001, 1'b0);
        send_translate(48'h0000_0000_1234);
        send_response(64'h0000_0000_0000_1001, 1'b0);
        send_response(64'h000F_FFFF_FFE0_0081, 1'b0);
        // Not present at PD with the page-size bit set
        send_translate(48'h0000_0000_1000);
        send_response(64'h0000_0000_0000_2001, 1'b0);
        send_response(64'h0000_0000_0000_3001, 1'b0);
        send_response(64'h0000_0000_0000_0080, 1'b0);

        run_random_walks(ITEMS_PER_PHASE);
        drain_walker();

        // Zero root, sender idles more than the receiver
        write_table_root('0);
        src_idle  = 49;
        sink_idle = 7;
        run_random_walks(2 * ITEMS_PER_PHASE);
        drain_walker();

        // Random root with random low bits, no idling at all
        write_table_root(ADDR_BITS'({$urandom, $urandom}));
        src_idle  = 0;
        sink_idle = 0;
        run_random_walks(3 * ITEMS_PER_PHASE);
        drain_walker();
        repeat (10) @(posedge clk);

        if (fail_count == 0 && pending_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: four_level_page_table_walker_core.f
hdl/pgw_pkg.sv
hdl/pgw_if.sv
hdl/four_level_page_table_walker_core.sv
dv/pgw_walk_checker.sv
dv/tb_four_level_page_table_walker_core.sv
